### src/hlxf_pkg.sv
// Shared types and constants for the header/length/XOR frame builder.
package hlxf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = CFG_IDX_W'(1);

  localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'h55;

  localparam logic [2:0] MAX_PUSH_BYTES = 3'd4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_SEND  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } hdr_cfg_t;

endpackage

### src/hlxf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hlxf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/hlxf_seq.sv
// Command sequencer: byte-serial payload append and frame streaming.
module hlxf_seq
  import hlxf_pkg::*;
#(
  parameter int unsigned PAYLOAD_CAP = 60
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [1:0]                     in_command,
  input  logic [31:0]                    in_value,
  input  logic [2:0]                     in_byte_count,
  input  hdr_cfg_t                       hdr,
  output logic                           busy,
  output logic                           ram_we,
  output logic [$clog2(PAYLOAD_CAP)-1:0] ram_waddr,
  output logic [7:0]                     ram_wdata,
  output logic [$clog2(PAYLOAD_CAP)-1:0] ram_raddr,
  input  logic [7:0]                     ram_rdata,
  output logic                           out_valid,
  output logic [7:0]                     out_frame_byte,
  output logic                           out_last_byte,
  output logic                           out_truncated
);

  localparam int unsigned ADDR_W = $clog2(PAYLOAD_CAP);
  localparam int unsigned CNT_W  = $clog2(PAYLOAD_CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_H2,
    S_LEN,
    S_PAY,
    S_CK
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [7:0]        xor_r;
  logic              ovf_r;
  logic [31:0]       val_r;
  logic [2:0]        rem_r;
  logic [ADDR_W-1:0] idx_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic              accept;
  logic              has_room;
  logic [2:0]        sat_cnt;
  logic [7:0]        len_byte;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign has_room  = (count_r < CNT_W'(PAYLOAD_CAP));
  assign sat_cnt   = (in_byte_count > MAX_PUSH_BYTES) ? MAX_PUSH_BYTES : in_byte_count;
  assign len_byte  = 8'(count_r);

  assign ram_we    = (state_r == S_PUSH) && has_room;
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_wdata = val_r[7:0];
  assign ram_raddr = (state_r == S_PAY) ? ADDR_W'(idx_r + 1'b1) : '0;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;
  assign out_truncated  = out_trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      xor_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      idx_r       <= '0;
      rem_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (cmd_t'(in_command))
              CMD_START: begin
                count_r <= '0;
                xor_r   <= '0;
                ovf_r   <= 1'b0;
              end
              CMD_PUSH: begin
                val_r <= in_value;
                rem_r <= sat_cnt;
                if (sat_cnt != 3'd0) begin
                  state_r <= S_PUSH;
                end
              end
              CMD_SEND: begin
                out_valid_r <= 1'b1;
                out_byte_r  <= hdr.first;
                out_trunc_r <= ovf_r;
                state_r     <= S_H2;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH: begin
          if (has_room) begin
            count_r <= count_r + CNT_W'(1);
            xor_r   <= xor_r ^ val_r[7:0];
          end else begin
            ovf_r <= 1'b1;
          end
          val_r <= {8'd0, val_r[31:8]};
          rem_r <= rem_r - 3'd1;
          if (rem_r == 3'd1) begin
            state_r <= S_IDLE;
          end
        end
        S_H2: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= hdr.second;
          out_trunc_r <= ovf_r;
          state_r     <= S_LEN;
        end
        S_LEN: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= len_byte;
          out_trunc_r <= ovf_r;
          idx_r       <= '0;
          state_r     <= (count_r == '0) ? S_CK : S_PAY;
        end
        S_PAY: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= ram_rdata;
          out_trunc_r <= ovf_r;
          idx_r       <= ADDR_W'(idx_r + 1'b1);
          if ((CNT_W'(idx_r) + CNT_W'(1)) == count_r) begin
            state_r <= S_CK;
          end
        end
        S_CK: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          out_byte_r  <= len_byte ^ xor_r;
          out_trunc_r <= ovf_r;
          count_r     <= '0;
          xor_r       <= '0;
          ovf_r       <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/header_length_xor_framer.sv
// Frame builder: start clears, push appends up to 4 bytes, send streams hdr/len/payload/XOR.
// Push: one byte per cycle for byte_count bytes (saturated at 4), with a store write while room remains.
// Send: payload_count + 4 result items on consecutive cycles, the first in the cycle after accept;
// the payload store read port paces the stream at one byte per cycle.
// busy is high while a push or send is in progress; results cannot be stalled.
// Synchronous reset clears frame state and loads header registers with 0xAA and 0x55.
module header_length_xor_framer
  import hlxf_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_value,
  input  logic [2:0]           in_byte_count,
  output logic                 out_valid,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last_byte,
  output logic                 out_truncated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int unsigned PAYLOAD_CAP = FRAME_BYTES - 4;
  localparam int unsigned ADDR_W      = $clog2(PAYLOAD_CAP);

  hdr_cfg_t          hdr_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first  <= HDR_FIRST_RST;
      hdr_r.second <= HDR_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HDR_FIRST) begin
        hdr_r.first <= cfg_data;
      end else if (cfg_index == REG_HDR_SECOND) begin
        hdr_r.second <= cfg_data;
      end
    end
  end

  hlxf_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CAP)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hlxf_seq #(
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_byte_count  (in_byte_count),
    .hdr            (hdr_r),
    .busy           (busy),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_truncated  (out_truncated)
  );

`ifndef ASSERT_OFF
  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_byte |-> out_valid)
    else $error("last_byte without strobe");

  a_send_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_SEND) |=> (busy && out_valid))
    else $error("send did not start streaming");

  a_push_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_PUSH) |=> !out_valid)
    else $error("push produced an item");
`endif

endmodule
